// File: hdl/fbs_pkg.sv
`default_nettype none
// ============================================================================
// fbs_pkg
// Shared types, constants and the ITA2 letters table for the FSK Baudot
// bit slicer.
// ============================================================================
package fbs_pkg;

    localparam int CODE_BITS   = 5;
    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 15;
    localparam int PERIOD_W    = 16;
    localparam int LETTER_W    = 7;
    localparam int BIT_IDX_W   = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2458;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'd1;

    localparam logic EV_CHAR = 1'b0;
    localparam logic EV_END  = 1'b1;

    localparam logic [LETTER_W-1:0] LETTER_LF = 7'h0A;

    typedef struct packed {
        logic                 event_kind;
        logic [CODE_BITS-1:0] code;
        logic [LETTER_W-1:0]  letter;
    } t_result;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [PERIOD_W-1:0] bit_period;
    } t_cfg;

    function automatic logic [LETTER_W-1:0] ita2_letter(input logic [CODE_BITS-1:0] code);
        logic [LETTER_W-1:0] ch;
        case (code)
            5'd0:    ch = 7'h2E;
            5'd1:    ch = 7'h45;
            5'd2:    ch = 7'h0D;
            5'd3:    ch = 7'h41;
            5'd4:    ch = 7'h20;
            5'd5:    ch = 7'h53;
            5'd6:    ch = 7'h49;
            5'd7:    ch = 7'h55;
            5'd8:    ch = 7'h0A;
            5'd9:    ch = 7'h44;
            5'd10:   ch = 7'h52;
            5'd11:   ch = 7'h4A;
            5'd12:   ch = 7'h4E;
            5'd13:   ch = 7'h46;
            5'd14:   ch = 7'h43;
            5'd15:   ch = 7'h4B;
            5'd16:   ch = 7'h54;
            5'd17:   ch = 7'h5A;
            5'd18:   ch = 7'h4C;
            5'd19:   ch = 7'h57;
            5'd20:   ch = 7'h48;
            5'd21:   ch = 7'h59;
            5'd22:   ch = 7'h50;
            5'd23:   ch = 7'h51;
            5'd24:   ch = 7'h4F;
            5'd25:   ch = 7'h42;
            5'd26:   ch = 7'h47;
            5'd27:   ch = 7'h20;
            5'd28:   ch = 7'h4D;
            5'd29:   ch = 7'h58;
            5'd30:   ch = 7'h56;
            5'd31:   ch = 7'h3B;
            default: ch = 7'h2E;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: hdl/fbs_in_stage.sv
`default_nettype none
// ============================================================================
// fbs_in_stage
// Input register: holds one accepted sample until the slicer consumes it.
// ============================================================================
module fbs_in_stage
    import fbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_consume,
    output logic                     o_valid,
    output logic [SAMPLE_W-1:0]      o_sample
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                n_valid;

    assign o_ready  = !r_valid || i_consume;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= i_sample;
        end
    end

endmodule
`default_nettype wire

// File: hdl/fbs_slicer.sv
`default_nettype none
// ============================================================================
// fbs_slicer
// Detection, mid-period slicing and code assembly; one sample per cycle while i_fire is high.
// ============================================================================
module fbs_slicer
    import fbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_cfg                i_cfg,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    logic                 r_detecting;
    logic [PERIOD_W-1:0]  r_phase;
    logic [CODE_BITS-1:0] r_code;
    logic [BIT_IDX_W-1:0] r_bit_idx;

    logic                 n_detecting;
    logic [PERIOD_W-1:0]  n_phase;
    logic [CODE_BITS-1:0] n_code;
    logic [BIT_IDX_W-1:0] n_bit_idx;

    logic signed [SAMPLE_W:0] s_ext;
    logic signed [SAMPLE_W:0] thr_pos;
    logic signed [SAMPLE_W:0] thr_neg;
    logic                     hi;
    logic                     lo;
    logic [PERIOD_W-1:0]      half_period;
    logic [PERIOD_W-1:0]      phase_mid;
    logic                     ended;

    always_comb begin
        s_ext       = signed'({i_sample[SAMPLE_W-1], i_sample});
        thr_pos     = signed'({2'b00, i_cfg.threshold});
        thr_neg     = -thr_pos;
        hi          = s_ext >= thr_pos;
        lo          = s_ext <= thr_neg;
        half_period = i_cfg.bit_period >> 1;

        n_detecting = r_detecting;
        n_code      = r_code;
        n_bit_idx   = r_bit_idx;
        phase_mid   = r_phase;
        ended       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{event_kind: EV_CHAR, code: r_code, letter: ita2_letter(r_code)};

        if (!r_detecting) begin
            if (hi || lo) begin
                n_detecting = 1'b1;
                phase_mid   = '0;
            end
        end else begin
            if (r_phase == half_period) begin
                if (hi) begin
                    n_code    = r_code | (CODE_BITS'(1) << r_bit_idx);
                    n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
                end else if (lo) begin
                    n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
                end else begin
                    ended       = 1'b1;
                    n_detecting = 1'b0;
                    phase_mid   = '0;
                    n_code      = '0;
                    n_bit_idx   = '0;
                    o_res_valid = 1'b1;
                    o_res       = '{event_kind: EV_END, code: '0, letter: LETTER_LF};
                end
            end
            if (phase_mid == i_cfg.bit_period) begin
                phase_mid = '0;
            end
            if (!ended && n_bit_idx >= BIT_IDX_W'(CODE_BITS)) begin
                o_res_valid = 1'b1;
                o_res       = '{event_kind: EV_CHAR, code: n_code,
                                letter: ita2_letter(n_code)};
                n_code      = '0;
                n_bit_idx   = '0;
            end
        end
        n_phase = phase_mid + PERIOD_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detecting <= 1'b0;
            r_phase     <= '0;
            r_code      <= '0;
            r_bit_idx   <= '0;
        end else if (i_fire) begin
            r_detecting <= n_detecting;
            r_phase     <= n_phase;
            r_code      <= n_code;
            r_bit_idx   <= n_bit_idx;
        end
    end

    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx < BIT_IDX_W'(CODE_BITS))
        else $error("bit index past code length");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.event_kind == EV_END) |=> !r_detecting)
        else $error("end event without return to idle");

    a_result_needs_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_detecting)
        else $error("result while idle");

    a_char_clears_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid) |=> (r_code == '0 && r_bit_idx == '0))
        else $error("code not cleared after result");

endmodule
`default_nettype wire

// File: hdl/fbs_out_stage.sv
`default_nettype none
// ============================================================================
// fbs_out_stage
// Result register: holds one result until the downstream side takes it.
// ============================================================================
module fbs_out_stage
    import fbs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// File: hdl/fsk_baudot_bit_slicer_core.sv
`default_nettype none
// ============================================================================
// fsk_baudot_bit_slicer_core
// ITA2 Baudot FSK bit slicer: detects a signal, slices each bit at mid
// period and emits the decoded letter or an end-of-signal event.
// ============================================================================
//  channel   dir   handshake              payload
//  s_axis    in    tvalid/tready          tdata[15:0] = sample (signed Q3.12)
//  m_axis    out   tvalid/tready          tdata = letter, code; tuser = event_kind
//  cfg       in    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  One sample per cycle unless a held result stalls; input and result are registered.
//  The rate is set by the input register feeding the slicer state update.
//  Reset clears detection state and loads threshold 2458, bit period 5000.
//  A held result stalls the slicer only when the result register is full.
// ============================================================================
module fsk_baudot_bit_slicer_core
    import fbs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [6:0] letter, [11:7] code, zero
    output logic                        m_axis_tuser,   // [0] event_kind
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg                r_cfg;
    logic                in_valid;
    logic [SAMPLE_W-1:0] in_sample;
    logic                out_free;
    logic                fire;
    logic                res_valid;
    t_result             res;
    t_result             out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= THRESH_RESET;
            r_cfg.bit_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[THRESH_W-1:0];
                CFG_BIT_PERIOD: r_cfg.bit_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign fire = in_valid && out_free;

    fbs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata),
        .i_consume (fire),
        .o_valid   (in_valid),
        .o_sample  (in_sample)
    );

    fbs_slicer u_slicer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_sample    (in_sample),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fbs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - CODE_BITS - LETTER_W){1'b0}},
                           out_res.code, out_res.letter};
    assign m_axis_tuser = out_res.event_kind;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the ITA2 Baudot FSK bit slicer core.
// Samples are streamed in under random source gaps and sink stalls. A
// tracker of the detection, mid-period slicing and 5-bit code assembly
// predicts every letter and end-of-signal event. Each result transfer is
// checked field by field. Directed tests cover threshold boundaries, zero and
// full-scale thresholds, short and odd bit periods, a counter running past a
// shortened period, and a long output stall. A random part follows.
// ============================================================================
module tb;
    import fbs_pkg::*;

    localparam int DEFAULT_THRESH = 2458;
    localparam int DEFAULT_PERIOD = 5000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int ROUND_ITEMS    = 75;
    localparam int MAX_GAP        = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int SHOWN_FAULTS   = 20;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    localparam logic [LETTER_W-1:0] GLYPHS [32] = '{
        7'h2E, 7'h45, 7'h0D, 7'h41, 7'h20, 7'h53, 7'h49, 7'h55,
        7'h0A, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43, 7'h4B,
        7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50, 7'h51,
        7'h4F, 7'h42, 7'h47, 7'h20, 7'h4D, 7'h58, 7'h56, 7'h3B
    };

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_W-1:0]     s_axis_tdata  = '0;      // [15:0] sample
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;            // [6:0] letter, [11:7] code, zero
    logic                    m_axis_tuser;            // [0] event_kind
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    // slicer tracker state
    logic                    sig_present;
    logic [PERIOD_W-1:0]     phase_ctr;
    logic [CODE_BITS-1:0]    code_bits;
    logic [BIT_IDX_W-1:0]    bits_taken;
    logic [THRESH_W-1:0]     cur_thresh;
    logic [PERIOD_W-1:0]     cur_period;

    t_result                 expected_events[$];

    int                      src_gap_max  = MAX_GAP;
    int                      sink_gap_max = MAX_GAP;
    int                      sink_hold    = 0;
    int                      fault_count  = 0;
    int                      samples_sent = 0;
    int                      reg_writes   = 0;
    int                      chars_seen   = 0;
    int                      ends_seen    = 0;
    int                      stall_cycles = 0;
    int unsigned             cycle_count  = 0;

    fsk_baudot_bit_slicer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) begin
            stall_cycles++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_events.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
            $display("%0t ERROR %s", $time, msg);
        end
    endtask

    // Advance the tracker by one accepted sample and queue any result it causes.
    task automatic track_slicer(input logic [SAMPLE_W-1:0] smp);
        int      sv;
        int      th;
        bit      hit_mark;
        bit      hit_space;
        bit      emit;
        t_result ev;
        sv        = $signed(smp);
        th        = cur_thresh;
        hit_mark  = (sv >= th);
        hit_space = (sv <= -th);
        emit      = 1'b0;
        ev        = '0;
        if (!sig_present) begin
            if (hit_mark || hit_space) begin
                sig_present = 1'b1;
                phase_ctr   = '0;
            end
        end else begin
            if (phase_ctr == (cur_period >> 1)) begin
                if (hit_mark) begin
                    code_bits[bits_taken] = 1'b1;
                    bits_taken = bits_taken + 1'b1;
                end else if (hit_space) begin
                    bits_taken = bits_taken + 1'b1;
                end else begin
                    sig_present = 1'b0;
                    phase_ctr   = '0;
                    code_bits   = '0;
                    bits_taken  = '0;
                    ev   = '{event_kind: EV_END, code: '0, letter: LETTER_LF};
                    emit = 1'b1;
                end
            end
            if (phase_ctr == cur_period) begin
                phase_ctr = '0;
            end
            if (bits_taken >= CODE_BITS) begin
                ev   = '{event_kind: EV_CHAR, code: code_bits, letter: GLYPHS[code_bits]};
                emit = 1'b1;
                code_bits  = '0;
                bits_taken = '0;
            end
        end
        phase_ctr = phase_ctr + 1'b1;
        if (emit) begin
            expected_events.push_back(ev);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] mark_level();
        int th;
        int k;
        th = cur_thresh;
        k  = ($urandom_range(0, 7) == 0) ? th : $urandom_range(th, 32767);
        return SAMPLE_W'(k);
    endfunction

    function automatic logic [SAMPLE_W-1:0] space_level();
        int th;
        int k;
        th = (cur_thresh == 0) ? 1 : cur_thresh;
        k  = ($urandom_range(0, 7) == 0) ? th : $urandom_range(th, 32768);
        return SAMPLE_W'(-k);
    endfunction

    function automatic logic [SAMPLE_W-1:0] gap_level();
        int th;
        int k;
        th = cur_thresh;
        if (th == 0) begin
            return '0;
        end
        k = ($urandom_range(0, 7) == 0) ? th - 1 : $urandom_range(0, th - 1);
        return ($urandom_range(0, 1) == 1) ? SAMPLE_W'(-k) : SAMPLE_W'(k);
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        int pause;
        pause = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
        if (pause > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        track_slicer(smp);
        samples_sent++;
    endtask

    task automatic stop_samples();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        stop_samples();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_THRESHOLD) begin
            cur_thresh = val[THRESH_W-1:0];
        end else begin
            cur_period = val;
        end
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Detect if idle, fill up to the mid-period point, then slice smp.
    task automatic run_to_slice(input logic [SAMPLE_W-1:0] smp);
        if (!sig_present) begin
            push_sample(($urandom_range(0, 1) == 1) ? mark_level() : space_level());
        end
        while (phase_ctr != (cur_period >> 1)) begin
            push_sample(SAMPLE_W'($urandom));
        end
        push_sample(smp);
    endtask

    task automatic send_code(input logic [CODE_BITS-1:0] c);
        for (int i = 0; i < CODE_BITS; i++) begin
            run_to_slice(c[i] ? mark_level() : space_level());
        end
    endtask

    task automatic drop_signal();
        if (sig_present) begin
            if (cur_period == 1) begin
                write_reg(CFG_BIT_PERIOD, 16'd2);
            end
            if (cur_thresh == 0) begin
                write_reg(CFG_THRESHOLD, 16'd1);
            end
            run_to_slice(gap_level());
        end
    endtask

    task automatic set_period(input logic [CFG_DATA_W-1:0] p);
        drop_signal();
        write_reg(CFG_BIT_PERIOD, p);
    endtask

    task automatic random_burst();
        int nbits;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6)) push_sample(SAMPLE_W'($urandom));
        end else begin
            nbits = $urandom_range(0, 11);
            repeat (nbits) run_to_slice(($urandom_range(0, 1) == 1) ? mark_level()
                                                                    : space_level());
            if ($urandom_range(0, 2) != 0 && cur_thresh != 0) begin
                run_to_slice(gap_level());
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser === EV_END) begin
                ends_seen++;
            end else begin
                chars_seen++;
            end
            if (expected_events.size() == 0) begin
                flag_fault($sformatf("unexpected result tdata=%h tuser=%b",
                                     m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_events.pop_front();
                if (m_axis_tuser !== want.event_kind) begin
                    flag_fault($sformatf("event_kind got %b want %b",
                                         m_axis_tuser, want.event_kind));
                end
                if (m_axis_tdata[LETTER_W-1:0] !== want.letter) begin
                    flag_fault($sformatf("letter got %h want %h",
                                         m_axis_tdata[LETTER_W-1:0], want.letter));
                end
                if (m_axis_tdata[LETTER_W +: CODE_BITS] !== want.code) begin
                    flag_fault($sformatf("code got %h want %h",
                                         m_axis_tdata[LETTER_W +: CODE_BITS], want.code));
                end
                if (m_axis_tdata[OUT_TDATA_W-1:LETTER_W+CODE_BITS] !== '0) begin
                    flag_fault($sformatf("tdata padding not zero: %h", m_axis_tdata));
                end
            end
        end
    end

    initial begin : result_sink
        int pause;
        forever begin
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end else begin
                pause = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
                if (pause > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid && sink_hold == 0);
        end
    end

    task automatic apply_reset();
        sig_present = 1'b0;
        phase_ctr   = '0;
        code_bits   = '0;
        bits_taken  = '0;
        cur_thresh  = THRESH_W'(DEFAULT_THRESH);
        cur_period  = PERIOD_W'(DEFAULT_PERIOD);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        src_gap_max = 0;
        push_sample(SAMPLE_W'(DEFAULT_THRESH - 1));
        push_sample(SAMPLE_W'(1 - DEFAULT_THRESH));
        push_sample(SAMPLE_W'(DEFAULT_THRESH));
        write_reg(CFG_BIT_PERIOD, 16'd2);
        run_to_slice(SAMPLE_W'(DEFAULT_THRESH - 1));
        push_sample(SAMPLE_W'(-DEFAULT_THRESH));
        src_gap_max = MAX_GAP;
    endtask

    task automatic test_edge_levels();
        write_reg(CFG_BIT_PERIOD, 16'd2);
        for (int i = 0; i < CODE_BITS; i++) begin
            run_to_slice(i[0] ? 16'h7FFF : SAMPLE_W'(DEFAULT_THRESH));
        end
        for (int i = 0; i < CODE_BITS; i++) begin
            run_to_slice(i[0] ? 16'h8000 : SAMPLE_W'(-DEFAULT_THRESH));
        end
        run_to_slice(SAMPLE_W'(DEFAULT_THRESH - 1));
        run_to_slice(SAMPLE_W'(1 - DEFAULT_THRESH));
        send_code(5'd8);
        send_code(5'd2);
    endtask

    task automatic test_threshold_limits();
        drop_signal();
        write_reg(CFG_THRESHOLD, '0);
        repeat (CODE_BITS) run_to_slice('0);
        send_code(5'b10010);
        drop_signal();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        push_sample(16'h8000);
        send_code(CODE_BITS'($urandom));
        run_to_slice(SAMPLE_W'(-32766));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(DEFAULT_THRESH));
    endtask

    task automatic test_short_periods();
        set_period(16'd3);
        send_code(CODE_BITS'($urandom));
        send_code(CODE_BITS'($urandom));
        set_period(16'd1);
        push_sample(mark_level());
        repeat (30) push_sample(SAMPLE_W'($urandom));
        write_reg(CFG_BIT_PERIOD, 16'd2);
        send_code(CODE_BITS'($urandom));
        drop_signal();
    endtask

    task automatic test_period_shrink();
        src_gap_max = 0;
        set_period(16'd40);
        run_to_slice(mark_level());
        repeat (4) push_sample(SAMPLE_W'($urandom));
        // counter is past the shorter period; let it run on until the longer one
        write_reg(CFG_BIT_PERIOD, 16'd10);
        repeat (10) push_sample(SAMPLE_W'($urandom));
        write_reg(CFG_BIT_PERIOD, 16'd80);
        run_to_slice(gap_level());
        src_gap_max = MAX_GAP;
    endtask

    task automatic test_backpressure();
        set_period(16'd2);
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold    = HOLD_CYCLES;
        repeat (40) run_to_slice(gap_level());
        repeat (3) send_code(CODE_BITS'($urandom));
        drop_signal();
        settle();
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
    endtask

    task automatic test_random();
        int first;
        int round_end;
        first = samples_sent;
        while (samples_sent - first < RANDOM_ITEMS) begin
            set_period(($urandom_range(0, 3) == 0) ? 16'd2
                                                   : CFG_DATA_W'($urandom_range(3, 12)));
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_THRESHOLD, '0);
                1:       write_reg(CFG_THRESHOLD, 16'hFFFF);
                2:       write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 4000)));
                default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(500, 12000)));
            endcase
            src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            round_end    = samples_sent + ROUND_ITEMS;
            while (samples_sent < round_end) begin
                random_burst();
            end
        end
        drop_signal();
    endtask

    initial begin
        apply_reset();
        test_reset_values();
        test_edge_levels();
        test_threshold_limits();
        test_short_periods();
        test_period_shrink();
        test_backpressure();
        test_random();
        settle();
        repeat (8) @(posedge i_clk);
        $display("Streamed %0d samples through %0d register writes; checked %0d letters",
                 samples_sent, reg_writes, chars_seen);
        $display("and %0d end events; input held back for %0d cycles by output stalls.",
                 ends_seen, stall_cycles);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/fbs_pkg.sv
hdl/fbs_in_stage.sv
hdl/fbs_slicer.sv
hdl/fbs_out_stage.sv
hdl/fsk_baudot_bit_slicer_core.sv
tb/tb.sv
